// ===== rtl/prcs_pkg.sv =====
// Shared types and constants for the particle/receptor contact checker.
// Used by prcs_ctrl, prcs_dp and particle_receptor_contact_step; no dependencies.
package prcs_pkg;

    // Fixed field widths
    localparam int OP_W       = 2;
    localparam int IDX_W      = 9;
    localparam int STATUS_W   = 3;
    localparam int HIT_W      = 9;
    localparam int COUNT_W    = 32;
    localparam int RADIUS_W   = 48;
    localparam int ACTIVE_W   = 10;
    localparam int CFG_ADDR_W = 2;

    // Distance magnitudes: at most 32 coordinate bits plus one for the difference.
    localparam int MAG_EXT_W  = 33;
    // A magnitude of this many bits squares into 48 bits; anything larger is
    // beyond every 48-bit bound.
    localparam int SQ_SAFE_W  = 24;
    localparam int SQ_W       = 2 * SQ_SAFE_W;
    localparam int SUM_W      = SQ_W + 2;

    // Result item layout
    localparam int OUT_FIELDS_W = STATUS_W + HIT_W + 2 * COUNT_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
    localparam logic [OP_W-1:0] OP_MOVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_PLACE = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] ST_LOADED     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_MOVED_FREE = 3'd1;
    localparam logic [STATUS_W-1:0] ST_LEFT_SPACE = 3'd2;
    localparam logic [STATUS_W-1:0] ST_CONTACT    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_PLACED     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_REJECTED   = 3'd5;
    localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd6;

    // Configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] CFG_SPACE_RADIUS_SQ   = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CONTACT_RADIUS_SQ = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACTIVE_RECEPTORS  = 2'd2;

    // Configuration reset values
    localparam logic [RADIUS_W-1:0] SPACE_RADIUS_SQ_RST   = 48'd429496729600;
    localparam logic [RADIUS_W-1:0] CONTACT_RADIUS_SQ_RST = 48'd4294967296;
    localparam logic [ACTIVE_W-1:0] ACTIVE_RECEPTORS_RST  = 10'd500;

    // Controller to datapath
    typedef struct packed {
        logic                load_in;
        logic                mem_write;
        logic                make_place;
        logic                make_move;
        logic                issue;
        logic                use_mem;
        logic                commit;
        logic                clr_need;
        logic                set_need;
        logic                count_move;
        logic                count_exit;
        logic                flush;
        logic                emit;
        logic [STATUS_W-1:0] status;
        logic [HIT_W-1:0]    hit_index;
    } prcs_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic                res_valid;
        logic                res_inside;
        logic                res_contact;
        logic                needs_placement;
        logic                idx_ok;
        logic                out_free;
        logic [ACTIVE_W-1:0] active_receptors;
    } prcs_stat_t;

endpackage

// ===== rtl/particle_receptor_contact_step.sv =====
// Particle/receptor contact checker, top level. A scanning move reads n receptor entries,
// n = min(active_receptors, RECEPTOR_SLOTS), and stops early at the first contact
// (one RAM read per cycle into a five-stage distance pipeline).
// Items are taken one at a time; a result waiting at the output holds off the next item.
// Synchronous active-low reset restores register defaults and requires a placement; RAM kept.
module particle_receptor_contact_step #(
    parameter int RECEPTOR_SLOTS = 512,
    parameter int COORD_BITS     = 24
) (
    input  logic aclk,
    input  logic aresetn,

    // input items
    input  logic s_tvalid,
    output logic s_tready,
    // operation[1:0], receptor_index[10:2], coord_x, coord_y, coord_z, zero pad
    input  logic [((prcs_pkg::OP_W + prcs_pkg::IDX_W + 3 * COORD_BITS + 7) / 8) * 8 - 1:0]
                 s_tdata,

    // result items
    output logic m_tvalid,
    input  logic m_tready,
    // status[2:0], hit_index[11:3], motion_count[43:12],
    // out_of_range_count[75:44], zero pad
    output logic [prcs_pkg::OUT_TDATA_W-1:0] m_tdata,

    // configuration writes
    input  logic                              cfg_we,
    input  logic [prcs_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [prcs_pkg::RADIUS_W-1:0]     cfg_wdata
);
    import prcs_pkg::*;

    localparam int C       = COORD_BITS;
    localparam int AW      = $clog2(RECEPTOR_SLOTS > 1 ? RECEPTOR_SLOTS : 2);
    localparam int X_LSB   = OP_W + IDX_W;

    prcs_cmd_t           cmd;
    prcs_stat_t          stat;
    logic [AW-1:0]       scan_addr;

    logic [STATUS_W-1:0] out_status;
    logic [HIT_W-1:0]    out_hit_index;
    logic [COUNT_W-1:0]  out_motion_count;
    logic [COUNT_W-1:0]  out_range_count;

    // Controller: accepts one item, runs it to completion, hands the result
    // to the output register and only then takes the next item.
    prcs_ctrl #(
        .RECEPTOR_SLOTS (RECEPTOR_SLOTS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (s_tdata[OP_W-1:0]),
        .stat      (stat),
        .cmd       (cmd),
        .scan_addr (scan_addr)
    );

    // Datapath: receptor RAM, probe/particle registers, distance pipeline,
    // saturating counters and the result register that frees the input side.
    prcs_dp #(
        .RECEPTOR_SLOTS (RECEPTOR_SLOTS),
        .COORD_BITS     (COORD_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_index         (s_tdata[OP_W +: IDX_W]),
        .in_x             (s_tdata[X_LSB +: C]),
        .in_y             (s_tdata[X_LSB + C +: C]),
        .in_z             (s_tdata[X_LSB + 2 * C +: C]),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .cmd              (cmd),
        .scan_addr        (scan_addr),
        .stat             (stat),
        .out_ready        (m_tready),
        .out_valid        (m_tvalid),
        .out_status       (out_status),
        .out_hit_index    (out_hit_index),
        .out_motion_count (out_motion_count),
        .out_range_count  (out_range_count)
    );

    // Pack the result item, lowest field first, pad to whole bytes.
    assign m_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}},
                      out_range_count, out_motion_count, out_hit_index, out_status};

endmodule

// ===== rtl/prcs_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module prcs_ram #(
    parameter int WIDTH = 72,
    parameter int DEPTH = 512
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]  raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/prcs_ctrl.sv =====
// Controller for the contact checker: sequences load, place, move and the
// receptor scan. Depends on prcs_pkg.
module prcs_ctrl #(
    parameter int RECEPTOR_SLOTS = 512
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic                                                  in_valid,
    output logic                                                  in_ready,
    input  logic [prcs_pkg::OP_W-1:0]                             in_op,
    input  prcs_pkg::prcs_stat_t                                  stat,
    output prcs_pkg::prcs_cmd_t                                   cmd,
    output logic [$clog2(RECEPTOR_SLOTS > 1 ? RECEPTOR_SLOTS : 2)-1:0] scan_addr
);
    import prcs_pkg::*;

    localparam int AW = $clog2(RECEPTOR_SLOTS > 1 ? RECEPTOR_SLOTS : 2);
    localparam int CW = $clog2(RECEPTOR_SLOTS + 1);
    localparam int EW = (CW > ACTIVE_W) ? CW : ACTIVE_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_PROBE,
        S_WAIT_PROBE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [HIT_W-1:0]    hit_reg, hit_next;
    logic [CW-1:0]       issue_reg, issue_next;
    logic [CW-1:0]       rcv_reg, rcv_next;
    logic [CW-1:0]       scan_len;
    logic [EW-1:0]       act_ext;
    logic [EW-1:0]       slots_ext;

    always_comb begin
        // clamp the scan to the table size
        act_ext   = EW'(stat.active_receptors);
        slots_ext = EW'(RECEPTOR_SLOTS);
        scan_len  = (act_ext > slots_ext) ? CW'(RECEPTOR_SLOTS) : act_ext[CW-1:0];

        state_next  = state_reg;
        op_next     = op_reg;
        status_next = status_reg;
        hit_next    = hit_reg;
        issue_next  = issue_reg;
        rcv_next    = rcv_reg;

        cmd           = '0;
        cmd.status    = status_reg;
        cmd.hit_index = hit_reg;
        in_ready      = (state_reg == S_IDLE);
        scan_addr     = issue_reg[AW-1:0];

        unique case (state_reg)
            S_IDLE: begin
                if (in_valid) begin
                    cmd.load_in = 1'b1;
                    op_next     = in_op;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                hit_next = '0;
                unique case (op_reg)
                    OP_LOAD: begin
                        cmd.mem_write = 1'b1;
                        status_next   = stat.idx_ok ? ST_LOADED : ST_IGNORED;
                        state_next    = S_FINISH;
                    end
                    OP_PLACE: begin
                        cmd.make_place = 1'b1;
                        state_next     = S_PROBE;
                    end
                    OP_MOVE: begin
                        if (stat.needs_placement) begin
                            status_next = ST_IGNORED;
                            state_next  = S_FINISH;
                        end else begin
                            cmd.make_move  = 1'b1;
                            cmd.count_move = 1'b1;
                            state_next     = S_PROBE;
                        end
                    end
                    default: begin
                        status_next = ST_IGNORED;
                        state_next  = S_FINISH;
                    end
                endcase
            end
            S_PROBE: begin
                // norm of the probe position itself
                cmd.issue  = 1'b1;
                state_next = S_WAIT_PROBE;
            end
            S_WAIT_PROBE: begin
                if (stat.res_valid) begin
                    if (op_reg == OP_PLACE) begin
                        if (stat.res_inside) begin
                            cmd.commit   = 1'b1;
                            cmd.clr_need = 1'b1;
                            status_next  = ST_PLACED;
                        end else begin
                            status_next  = ST_REJECTED;
                        end
                        state_next = S_FINISH;
                    end else begin
                        cmd.commit = 1'b1;
                        if (!stat.res_inside) begin
                            cmd.count_exit = 1'b1;
                            cmd.set_need   = 1'b1;
                            status_next    = ST_LEFT_SPACE;
                            state_next     = S_FINISH;
                        end else if (scan_len == '0) begin
                            status_next = ST_MOVED_FREE;
                            state_next  = S_FINISH;
                        end else begin
                            issue_next = '0;
                            rcv_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (issue_reg < scan_len) begin
                    cmd.issue   = 1'b1;
                    cmd.use_mem = 1'b1;
                    issue_next  = issue_reg + 1'b1;
                end
                if (stat.res_valid) begin
                    // results return in index order; first contact is the lowest
                    if (stat.res_contact) begin
                        cmd.flush   = 1'b1;
                        hit_next    = HIT_W'(rcv_reg);
                        status_next = ST_CONTACT;
                        state_next  = S_FINISH;
                    end else if (rcv_reg + 1'b1 == scan_len) begin
                        status_next = ST_MOVED_FREE;
                        state_next  = S_FINISH;
                    end else begin
                        rcv_next = rcv_reg + 1'b1;
                    end
                end
            end
            S_FINISH: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            op_reg     <= '0;
            status_reg <= '0;
            hit_reg    <= '0;
            issue_reg  <= '0;
            rcv_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            op_reg     <= op_next;
            status_reg <= status_next;
            hit_reg    <= hit_next;
            issue_reg  <= issue_next;
            rcv_reg    <= rcv_next;
        end
    end

endmodule

// ===== rtl/prcs_dp.sv =====
// Datapath for the contact checker: particle state, receptor RAM, squared
// distance pipeline, counters, configuration and result register.
// Depends on prcs_pkg and prcs_ram.
module prcs_dp #(
    parameter int RECEPTOR_SLOTS = 512,
    parameter int COORD_BITS     = 24
) (
    input  logic                                                  aclk,
    input  logic                                                  aresetn,
    input  logic [prcs_pkg::IDX_W-1:0]                            in_index,
    input  logic signed [COORD_BITS-1:0]                          in_x,
    input  logic signed [COORD_BITS-1:0]                          in_y,
    input  logic signed [COORD_BITS-1:0]                          in_z,
    input  logic                                                  cfg_we,
    input  logic [prcs_pkg::CFG_ADDR_W-1:0]                       cfg_addr,
    input  logic [prcs_pkg::RADIUS_W-1:0]                         cfg_wdata,
    input  prcs_pkg::prcs_cmd_t                                   cmd,
    input  logic [$clog2(RECEPTOR_SLOTS > 1 ? RECEPTOR_SLOTS : 2)-1:0] scan_addr,
    output prcs_pkg::prcs_stat_t                                  stat,
    input  logic                                                  out_ready,
    output logic                                                  out_valid,
    output logic [prcs_pkg::STATUS_W-1:0]                         out_status,
    output logic [prcs_pkg::HIT_W-1:0]                            out_hit_index,
    output logic [prcs_pkg::COUNT_W-1:0]                          out_motion_count,
    output logic [prcs_pkg::COUNT_W-1:0]                          out_range_count
);
    import prcs_pkg::*;

    localparam int C  = COORD_BITS;
    localparam int AW = $clog2(RECEPTOR_SLOTS > 1 ? RECEPTOR_SLOTS : 2);

    function automatic logic signed [C-1:0] sat_add(input logic signed [C-1:0] a,
                                                    input logic signed [C-1:0] b);
        logic signed [C:0] s;
        s = {a[C-1], a} + {b[C-1], b};
        if (s[C] != s[C-1]) begin
            sat_add = s[C] ? {1'b1, {(C-1){1'b0}}} : {1'b0, {(C-1){1'b1}}};
        end else begin
            sat_add = s[C-1:0];
        end
    endfunction

    function automatic logic [C:0] abs_diff(input logic signed [C:0] d);
        abs_diff = d[C] ? -d : d;
    endfunction

    // configuration
    logic [RADIUS_W-1:0] space_reg, contact_reg;
    logic [ACTIVE_W-1:0] active_reg;

    // captured input item
    logic [IDX_W-1:0]    idx_reg;
    logic signed [C-1:0] in_x_reg, in_y_reg, in_z_reg;
    logic                idx_ok;

    // particle and probe position
    logic signed [C-1:0] part_x_reg, part_y_reg, part_z_reg;
    logic signed [C-1:0] probe_x_reg, probe_y_reg, probe_z_reg;
    logic                need_reg;

    logic [COUNT_W-1:0]  moves_reg, exits_reg;

    // receptor RAM
    logic                mem_we;
    logic [3*C-1:0]      mem_rdata;
    logic signed [C-1:0] sub_x, sub_y, sub_z;

    // distance pipeline
    logic                    t0_valid_reg, t0_mem_reg;
    logic                    d1_valid_reg;
    logic signed [C:0]       d1_x_reg, d1_y_reg, d1_z_reg;
    logic [MAG_EXT_W-1:0]    mag_x, mag_y, mag_z;
    logic                    m2_valid_reg, m2_big_reg;
    logic [SQ_SAFE_W-1:0]    m2_x_reg, m2_y_reg, m2_z_reg;
    logic                    s3_valid_reg, s3_big_reg;
    logic [SQ_W-1:0]         s3_x_reg, s3_y_reg, s3_z_reg;
    logic [SUM_W-1:0]        sum;
    logic                    res_valid_reg, res_inside_reg, res_contact_reg;

    // result register
    logic                    out_valid_reg;
    logic [STATUS_W-1:0]     out_status_reg;
    logic [HIT_W-1:0]        out_hit_reg;
    logic [COUNT_W-1:0]      out_moves_reg, out_exits_reg;

    assign idx_ok = (32'(idx_reg) < 32'(RECEPTOR_SLOTS));
    assign mem_we = cmd.mem_write & idx_ok;

    prcs_ram #(
        .WIDTH (3 * C),
        .DEPTH (RECEPTOR_SLOTS)
    ) u_ram (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (AW'(idx_reg)),
        .wdata ({in_z_reg, in_y_reg, in_x_reg}),
        .raddr (scan_addr),
        .rdata (mem_rdata)
    );

    always_comb begin
        sub_x = t0_mem_reg ? mem_rdata[C-1:0]     : '0;
        sub_y = t0_mem_reg ? mem_rdata[2*C-1:C]   : '0;
        sub_z = t0_mem_reg ? mem_rdata[3*C-1:2*C] : '0;

        mag_x = MAG_EXT_W'(abs_diff(d1_x_reg));
        mag_y = MAG_EXT_W'(abs_diff(d1_y_reg));
        mag_z = MAG_EXT_W'(abs_diff(d1_z_reg));

        sum = SUM_W'(s3_x_reg) + SUM_W'(s3_y_reg) + SUM_W'(s3_z_reg);
    end

    // control state: config, particle status, counters, pipeline valids
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            space_reg     <= SPACE_RADIUS_SQ_RST;
            contact_reg   <= CONTACT_RADIUS_SQ_RST;
            active_reg    <= ACTIVE_RECEPTORS_RST;
            part_x_reg    <= '0;
            part_y_reg    <= '0;
            part_z_reg    <= '0;
            need_reg      <= 1'b1;
            moves_reg     <= '0;
            exits_reg     <= '0;
            t0_valid_reg  <= 1'b0;
            d1_valid_reg  <= 1'b0;
            m2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    CFG_SPACE_RADIUS_SQ:   space_reg   <= cfg_wdata;
                    CFG_CONTACT_RADIUS_SQ: contact_reg <= cfg_wdata;
                    CFG_ACTIVE_RECEPTORS:  active_reg  <= cfg_wdata[ACTIVE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.commit) begin
                part_x_reg <= probe_x_reg;
                part_y_reg <= probe_y_reg;
                part_z_reg <= probe_z_reg;
            end
            if (cmd.set_need) begin
                need_reg <= 1'b1;
            end else if (cmd.clr_need) begin
                need_reg <= 1'b0;
            end
            if (cmd.count_move && moves_reg != '1) begin
                moves_reg <= moves_reg + 1'b1;
            end
            if (cmd.count_exit && exits_reg != '1) begin
                exits_reg <= exits_reg + 1'b1;
            end
            // flush drops everything still in flight after a hit
            t0_valid_reg  <= cmd.issue & ~cmd.flush;
            d1_valid_reg  <= t0_valid_reg & ~cmd.flush;
            m2_valid_reg  <= d1_valid_reg & ~cmd.flush;
            s3_valid_reg  <= m2_valid_reg & ~cmd.flush;
            res_valid_reg <= s3_valid_reg & ~cmd.flush;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            idx_reg  <= in_index;
            in_x_reg <= in_x;
            in_y_reg <= in_y;
            in_z_reg <= in_z;
        end
        if (cmd.make_place) begin
            probe_x_reg <= in_x_reg;
            probe_y_reg <= in_y_reg;
            probe_z_reg <= in_z_reg;
        end else if (cmd.make_move) begin
            probe_x_reg <= sat_add(part_x_reg, in_x_reg);
            probe_y_reg <= sat_add(part_y_reg, in_y_reg);
            probe_z_reg <= sat_add(part_z_reg, in_z_reg);
        end

        t0_mem_reg <= cmd.use_mem;

        // difference to the receptor (or to the origin)
        d1_x_reg <= {probe_x_reg[C-1], probe_x_reg} - {sub_x[C-1], sub_x};
        d1_y_reg <= {probe_y_reg[C-1], probe_y_reg} - {sub_y[C-1], sub_y};
        d1_z_reg <= {probe_z_reg[C-1], probe_z_reg} - {sub_z[C-1], sub_z};

        // magnitude; a large one puts the sum past any 48-bit bound
        m2_x_reg   <= mag_x[SQ_SAFE_W-1:0];
        m2_y_reg   <= mag_y[SQ_SAFE_W-1:0];
        m2_z_reg   <= mag_z[SQ_SAFE_W-1:0];
        m2_big_reg <= (|mag_x[MAG_EXT_W-1:SQ_SAFE_W]) | (|mag_y[MAG_EXT_W-1:SQ_SAFE_W])
                    | (|mag_z[MAG_EXT_W-1:SQ_SAFE_W]);

        s3_x_reg   <= SQ_W'(m2_x_reg) * SQ_W'(m2_x_reg);
        s3_y_reg   <= SQ_W'(m2_y_reg) * SQ_W'(m2_y_reg);
        s3_z_reg   <= SQ_W'(m2_z_reg) * SQ_W'(m2_z_reg);
        s3_big_reg <= m2_big_reg;

        res_inside_reg  <= ~s3_big_reg & (sum <= SUM_W'(space_reg));
        res_contact_reg <= ~s3_big_reg & (sum <  SUM_W'(contact_reg));

        if (cmd.emit) begin
            out_status_reg <= cmd.status;
            out_hit_reg    <= cmd.hit_index;
            out_moves_reg  <= moves_reg;
            out_exits_reg  <= exits_reg;
        end
    end

    always_comb begin
        stat.res_valid        = res_valid_reg;
        stat.res_inside       = res_inside_reg;
        stat.res_contact      = res_contact_reg;
        stat.needs_placement  = need_reg;
        stat.idx_ok           = idx_ok;
        stat.out_free         = ~out_valid_reg | out_ready;
        stat.active_receptors = active_reg;
    end

    assign out_valid        = out_valid_reg;
    assign out_status       = out_status_reg;
    assign out_hit_index    = out_hit_reg;
    assign out_motion_count = out_moves_reg;
    assign out_range_count  = out_exits_reg;

endmodule
